[rtl/core/rhp_pkg.sv]
// Shared widths, sector codes and types of the RGB to HSV pixel unit.
package rhp_pkg;

    localparam int CH_W   = 8;
    localparam int HUE_W  = 9;
    localparam int SAT_W  = 8;
    localparam int DIFF_W = CH_W + 1;
    localparam int D60_W  = 16;
    localparam int NUM_W  = 17;
    localparam int QUO_W  = 9;

    localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(359);

    typedef logic [1:0] t_sector;

    localparam t_sector SEC_RED   = 2'd0;
    localparam t_sector SEC_GREEN = 2'd1;
    localparam t_sector SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic            grey;
        logic [CH_W-1:0] value;
    } t_side;

endpackage

[rtl/core/rgb_to_hsv_pixel_unit.sv]
// Top level of the RGB to HSV pixel unit: sector decode, numerators and two dividers.
//
// This unit converts one 8-bit RGB pixel word per clock into hue (whole degrees,
// 0..359), saturation (floor of 255 * chroma / max) and value (the largest
// channel). A pixel is taken at any rising edge where start is high; busy is
// always low because the datapath is a fully pipelined chain with no feedback,
// so a new word may follow in every cycle. Each result appears on the output
// ports for exactly one cycle, flagged by o_valid, once the word has gone
// through three front stages (channel max/min and sector, chroma and scaled
// difference, hue and saturation numerators), nine stages of the two parallel
// restoring dividers (one quotient bit per stage, set by the 9-bit hue
// quotient), and one output register. Results leave in the order the pixels
// came in. The receiver cannot hold results off, so it must take every word in
// the cycle it is shown. Grey and black pixels give zero hue and saturation.
module rgb_to_hsv_pixel_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rhp_pkg::CH_W-1:0]      i_red,
    input  logic [rhp_pkg::CH_W-1:0]      i_green,
    input  logic [rhp_pkg::CH_W-1:0]      i_blue,
    output logic                          o_valid,
    output logic [rhp_pkg::HUE_W-1:0]     o_hue,
    output logic [rhp_pkg::SAT_W-1:0]     o_saturation,
    output logic [rhp_pkg::CH_W-1:0]      o_value_level
);

    localparam int CH_W   = rhp_pkg::CH_W;
    localparam int DIFF_W = rhp_pkg::DIFF_W;
    localparam int D60_W  = rhp_pkg::D60_W;
    localparam int NUM_W  = rhp_pkg::NUM_W;
    localparam int QUO_W  = rhp_pkg::QUO_W;

    // The pipeline never stalls, so the unit is always ready for a new word.
    assign busy = 1'b0;

    // Stage 1: largest and smallest channel, the sector holding the maximum and
    // the signed difference of the two other channels.
    logic [CH_W-1:0]          n_s1_mx, n_s1_mn;
    rhp_pkg::t_sector         n_s1_sec;
    logic signed [DIFF_W-1:0] n_s1_diff;
    logic signed [DIFF_W-1:0] d_gb, d_br, d_rg;

    logic                     r_s1_valid;
    logic [CH_W-1:0]          r_s1_mx, r_s1_mn;
    rhp_pkg::t_sector         r_s1_sec;
    logic signed [DIFF_W-1:0] r_s1_diff;

    assign d_gb = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
    assign d_br = $signed({1'b0, i_blue})  - $signed({1'b0, i_red});
    assign d_rg = $signed({1'b0, i_red})   - $signed({1'b0, i_green});

    always_comb begin
        n_s1_mx = (i_red > i_green) ? i_red : i_green;
        if (i_blue > n_s1_mx) begin
            n_s1_mx = i_blue;
        end
        n_s1_mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < n_s1_mn) begin
            n_s1_mn = i_blue;
        end
        // Ties go to red first, then green, as the hue definition requires.
        if (i_red == n_s1_mx) begin
            n_s1_sec = rhp_pkg::SEC_RED;
        end else if (i_green == n_s1_mx) begin
            n_s1_sec = rhp_pkg::SEC_GREEN;
        end else begin
            n_s1_sec = rhp_pkg::SEC_BLUE;
        end
        case (n_s1_sec)
            rhp_pkg::SEC_RED:   n_s1_diff = d_gb;
            rhp_pkg::SEC_GREEN: n_s1_diff = d_br;
            default:            n_s1_diff = d_rg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start & ~busy;
        end
        r_s1_mx   <= n_s1_mx;
        r_s1_mn   <= n_s1_mn;
        r_s1_sec  <= n_s1_sec;
        r_s1_diff <= n_s1_diff;
    end

    // Stage 2: chroma and sixty times the channel difference (64x - 4x).
    logic [CH_W-1:0]         n_s2_d;
    logic signed [D60_W-1:0] n_s2_d60;

    logic                    r_s2_valid;
    logic [CH_W-1:0]         r_s2_mx, r_s2_d;
    rhp_pkg::t_sector        r_s2_sec;
    logic signed [D60_W-1:0] r_s2_d60;

    assign n_s2_d   = r_s1_mx - r_s1_mn;
    assign n_s2_d60 = (D60_W'(r_s1_diff) <<< 6) - (D60_W'(r_s1_diff) <<< 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_mx  <= r_s1_mx;
        r_s2_d   <= n_s2_d;
        r_s2_sec <= r_s1_sec;
        r_s2_d60 <= n_s2_d60;
    end

    // Stage 3: hue numerator, sector offset times chroma plus the scaled
    // difference, and saturation numerator 255 * chroma. Only the red sector can
    // go negative; it then wraps by a full turn of 360 * chroma.
    logic [NUM_W-1:0]        d_ext;
    logic [NUM_W-1:0]        n_s3_base;
    logic signed [NUM_W:0]   n_s3_hnum;
    logic [NUM_W-1:0]        n_s3_snum;

    logic                    r_s3_valid;
    logic [NUM_W-1:0]        r_s3_hnum, r_s3_snum;
    logic [CH_W-1:0]         r_s3_d;
    rhp_pkg::t_side          r_s3_side;

    assign d_ext = NUM_W'(r_s2_d);

    always_comb begin
        case (r_s2_sec)
            rhp_pkg::SEC_RED: begin
                n_s3_base = r_s2_d60[D60_W-1]
                          ? (d_ext << 8) + (d_ext << 6) + (d_ext << 5) + (d_ext << 3)
                          : '0;
            end
            rhp_pkg::SEC_GREEN: n_s3_base = (d_ext << 7) - (d_ext << 3);
            default:            n_s3_base = (d_ext << 8) - (d_ext << 4);
        endcase
    end

    assign n_s3_hnum = $signed({1'b0, n_s3_base}) + (NUM_W+1)'(r_s2_d60);
    assign n_s3_snum = (d_ext << 8) - d_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_hnum       <= n_s3_hnum[NUM_W-1:0];
        r_s3_snum       <= n_s3_snum;
        r_s3_d          <= r_s2_d;
        r_s3_side.grey  <= (r_s2_d == '0);
        r_s3_side.value <= r_s2_mx;
    end

    // Dividers: hue by chroma and saturation by the maximum, side by side. A zero
    // divisor gives a meaningless quotient that the grey flag masks later.
    logic [QUO_W-1:0] hue_quo, sat_quo;

    rhp_div_pipe u_hue_div (
        .i_clk (i_clk),
        .i_num (r_s3_hnum),
        .i_den (r_s3_d),
        .o_quo (hue_quo)
    );

    rhp_div_pipe u_sat_div (
        .i_clk (i_clk),
        .i_num (r_s3_snum),
        .i_den (r_s3_side.value),
        .o_quo (sat_quo)
    );

    // Valid bit and the grey flag and value travel beside the dividers.
    logic           r_dv_valid [0:QUO_W-1];
    rhp_pkg::t_side r_dv_side  [0:QUO_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUO_W; i++) begin
                r_dv_valid[i] <= 1'b0;
            end
        end else begin
            r_dv_valid[0] <= r_s3_valid;
            for (int i = 1; i < QUO_W; i++) begin
                r_dv_valid[i] <= r_dv_valid[i-1];
            end
        end
        r_dv_side[0] <= r_s3_side;
        for (int i = 1; i < QUO_W; i++) begin
            r_dv_side[i] <= r_dv_side[i-1];
        end
    end

    // Output register: clamp hue to 359 and force zeros for grey pixels.
    rhp_pkg::t_side          side_out;
    logic [rhp_pkg::HUE_W-1:0] n_hue;
    logic [rhp_pkg::SAT_W-1:0] n_sat;

    logic                      r_out_valid;
    logic [rhp_pkg::HUE_W-1:0] r_hue;
    logic [rhp_pkg::SAT_W-1:0] r_sat;
    logic [CH_W-1:0]           r_value;

    assign side_out = r_dv_side[QUO_W-1];

    always_comb begin
        if (side_out.grey) begin
            n_hue = '0;
            n_sat = '0;
        end else begin
            n_hue = (hue_quo > rhp_pkg::HUE_MAX) ? rhp_pkg::HUE_MAX : hue_quo;
            n_sat = sat_quo[rhp_pkg::SAT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_dv_valid[QUO_W-1];
        end
        r_hue   <= n_hue;
        r_sat   <= n_sat;
        r_value <= side_out.value;
    end

    assign o_valid       = r_out_valid;
    assign o_hue         = r_hue;
    assign o_saturation  = r_sat;
    assign o_value_level = r_value;

endmodule

[rtl/core/rhp_div_pipe.sv]
// Pipelined restoring divider: one quotient bit per register stage.
module rhp_div_pipe (
    input  logic                           i_clk,
    input  logic [rhp_pkg::NUM_W-1:0]      i_num,
    input  logic [rhp_pkg::CH_W-1:0]       i_den,
    output logic [rhp_pkg::QUO_W-1:0]      o_quo
);

    localparam int NUM_W = rhp_pkg::NUM_W;
    localparam int QUO_W = rhp_pkg::QUO_W;
    localparam int CH_W  = rhp_pkg::CH_W;

    logic [NUM_W-1:0] r_rem [0:QUO_W-2];
    logic [CH_W-1:0]  r_den [0:QUO_W-2];
    logic [QUO_W-1:0] r_quo [0:QUO_W-1];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_step
            logic [NUM_W-1:0] rem_in;
            logic [CH_W-1:0]  den_in;
            logic [QUO_W-1:0] quo_in;
            logic [NUM_W-1:0] trial;
            logic             take;
            logic [QUO_W-1:0] n_quo;

            if (k == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign den_in = r_den[k-1];
                assign quo_in = r_quo[k-1];
            end

            // The shifted divisor fits since the quotient is known to stay below 2^QUO_W.
            assign trial = {{(NUM_W-CH_W){1'b0}}, den_in} << (QUO_W-1-k);
            assign take  = (rem_in >= trial);
            assign n_quo = quo_in | (QUO_W'(take) << (QUO_W-1-k));

            always_ff @(posedge i_clk) begin
                r_quo[k] <= n_quo;
            end

            if (k < QUO_W-1) begin : g_carry
                logic [NUM_W-1:0] n_rem;

                assign n_rem = take ? (rem_in - trial) : rem_in;

                always_ff @(posedge i_clk) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[QUO_W-1];

endmodule
